@@ hw/rtl/ipv4_prefix_trie_lpm_macros.svh @@
// assertion macros for the ipv4 prefix trie block
// used by ipv4_prefix_trie_lpm.sv, no other dependencies
`ifndef IPV4_PREFIX_TRIE_LPM_MACROS_SVH
`define IPV4_PREFIX_TRIE_LPM_MACROS_SVH

// antecedent holds in the same cycle as consequent
`define IPTL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after antecedent
`define IPTL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/iptl_pkg.sv @@
// shared constants for the ipv4 prefix trie block
// no dependencies
package iptl_pkg;

    localparam int NODE_COUNT_DEF   = 1024;
    localparam int ADDRESS_BITS_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int ADDR_W   = 32;
    localparam int PLEN_W   = 6;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

@@ hw/rtl/iptl_ram.sv @@
// simple dual port ram, one write and one registered read per cycle
// depends on nothing
module iptl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ipv4_prefix_trie_lpm.sv @@
// top level of the ipv4 longest prefix match binary trie
// depends on iptl_pkg, iptl_ram and ipv4_prefix_trie_lpm_macros.svh
//
// one transaction in on s_axis (opcode, address, prefix_length), one result
// out on m_axis (status, match_found, match_length). opcode 0 looks up the
// longest marked prefix on the address path, 1 inserts a prefix, 2 deletes.
// a sequencer walks one trie level at a time through the node ram read port:
// each level is one node read plus one decision state. a lookup walks at
// most ADDRESS_BITS levels. an insert level that allocates a node passes
// through S_LINK and S_CLEAR in place of the read, and through S_POP before
// them when the node comes from the free stack. a delete walks prefix_length
// levels. s_tready is high only while the sequencer is idle.
// the result sits in an output register until m_tready takes it; a new item
// may be accepted meanwhile, but its result waits until the register frees.
// reset (aresetn low, synchronous) empties the trie: root without children
// or mark, free stack empty, next fresh node 1. node ram needs no clearing,
// an entry is always written when its node is allocated.
module ipv4_prefix_trie_lpm #(
    parameter int NODE_COUNT   = iptl_pkg::NODE_COUNT_DEF,
    parameter int ADDRESS_BITS = iptl_pkg::ADDRESS_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[1:0], address[33:2], prefix_length[39:34]
    input  logic [iptl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], match_found[2], match_length[8:3], zero fill
    output logic [iptl_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = IW + 1;
    localparam int NW = 2 * IW + 1 + iptl_pkg::PLEN_W;
    localparam int PW = iptl_pkg::PLEN_W;
    localparam logic [PW-1:0] ABITS = PW'(ADDRESS_BITS);
    localparam logic [CW-1:0] NODES = CW'(NODE_COUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_LOAD, S_POP, S_LINK, S_CLEAR, S_FIN
    } state_t;

    state_t                       state_reg;
    logic [iptl_pkg::OPCODE_W-1:0] op_reg;
    logic [ADDRESS_BITS-1:0]      addr_reg;
    logic [PW-1:0]                len_reg;
    logic [PW-1:0]                level_reg;
    logic [IW-1:0]                cur_idx_reg, cur_zero_reg, cur_one_reg;
    logic                         cur_mark_reg;
    logic [PW-1:0]                cur_len_reg;
    logic [IW-1:0]                par_idx_reg, par_zero_reg, par_one_reg;
    logic                         par_mark_reg;
    logic [PW-1:0]                par_len_reg;
    logic                         lastbit_reg;
    logic [IW-1:0]                root_zero_reg, root_one_reg;
    logic                         root_mark_reg;
    logic [PW-1:0]                root_len_reg;
    logic [IW-1:0]                new_idx_reg;
    logic [CW-1:0]                rel_cnt_reg, fresh_reg;
    logic                         found_reg;
    logic [PW-1:0]                best_reg;
    logic [iptl_pkg::STATUS_W-1:0] status_reg;
    logic                         m_tvalid_reg;
    logic [iptl_pkg::STATUS_W-1:0] m_status_reg;
    logic                         m_found_reg;
    logic [PW-1:0]                m_len_reg;

    logic          bit_cur;
    logic [IW-1:0] nx;
    logic          wr_en;
    logic [IW-1:0] wr_idx, wr_zero, wr_one;
    logic          wr_mark;
    logic [PW-1:0] wr_len;
    logic [IW-1:0] node_raddr;
    logic [NW-1:0] node_rdata;
    logic          push_en;
    logic [IW-1:0] stack_rdata;
    logic [CW-1:0] rel_dec;
    logic [IW-1:0] rd_zero, rd_one;
    logic          rd_mark;
    logic [PW-1:0] rd_len;
    logic [PW-1:0] s_len_sat;
    logic          leaf;

    assign bit_cur = addr_reg[ADDRESS_BITS-1];
    assign nx      = bit_cur ? cur_one_reg : cur_zero_reg;
    assign rel_dec = rel_cnt_reg - CW'(1);
    assign leaf    = (cur_idx_reg != '0) && (cur_zero_reg == '0) && (cur_one_reg == '0);
    assign {rd_len, rd_mark, rd_one, rd_zero} = node_rdata;
    assign s_len_sat = (s_tdata[34 +: PW] > ABITS) ? ABITS : s_tdata[34 +: PW];

    // node writes and free stack push
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = cur_idx_reg;
        wr_zero = cur_zero_reg;
        wr_one  = cur_one_reg;
        wr_mark = cur_mark_reg;
        wr_len  = cur_len_reg;
        push_en = 1'b0;
        case (state_reg)
            S_WALK: begin
                if (op_reg == iptl_pkg::OP_INSERT && level_reg == len_reg) begin
                    wr_en   = 1'b1;
                    wr_mark = 1'b1;
                    wr_len  = len_reg;
                end else if (op_reg == iptl_pkg::OP_DELETE && level_reg == len_reg) begin
                    wr_en = 1'b1;
                    if (leaf) begin
                        wr_idx  = par_idx_reg;
                        wr_zero = lastbit_reg ? par_zero_reg : '0;
                        wr_one  = lastbit_reg ? '0 : par_one_reg;
                        wr_mark = par_mark_reg;
                        wr_len  = par_len_reg;
                        push_en = rel_cnt_reg < NODES;
                    end else begin
                        wr_mark = 1'b0;
                    end
                end
            end
            S_LINK: begin
                wr_en   = 1'b1;
                wr_zero = bit_cur ? cur_zero_reg : new_idx_reg;
                wr_one  = bit_cur ? new_idx_reg : cur_one_reg;
            end
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_zero = '0;
                wr_one  = '0;
                wr_mark = 1'b0;
                wr_len  = '0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign node_raddr = nx;

    iptl_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_node_ram (
        .aclk  (aclk),
        .we    (wr_en && wr_idx != '0),
        .waddr (wr_idx),
        .wdata ({wr_len, wr_mark, wr_one, wr_zero}),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    iptl_ram #(.DEPTH(NODE_COUNT), .WIDTH(IW)) u_stack_ram (
        .aclk  (aclk),
        .we    (push_en),
        .waddr (rel_cnt_reg[IW-1:0]),
        .wdata (cur_idx_reg),
        .raddr (rel_dec[IW-1:0]),
        .rdata (stack_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            root_zero_reg <= '0;
            root_one_reg  <= '0;
            root_mark_reg <= 1'b0;
            rel_cnt_reg   <= '0;
            fresh_reg     <= CW'(1);
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            if (wr_en && wr_idx == '0) begin
                root_zero_reg <= wr_zero;
                root_one_reg  <= wr_one;
                root_mark_reg <= wr_mark;
                root_len_reg  <= wr_len;
            end
            if (push_en) begin
                rel_cnt_reg <= rel_cnt_reg + CW'(1);
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg       <= s_tdata[1:0];
                        addr_reg     <= s_tdata[2 +: ADDRESS_BITS];
                        len_reg      <= s_len_sat;
                        level_reg    <= '0;
                        cur_idx_reg  <= '0;
                        cur_zero_reg <= root_zero_reg;
                        cur_one_reg  <= root_one_reg;
                        cur_mark_reg <= root_mark_reg;
                        cur_len_reg  <= root_len_reg;
                        found_reg    <= 1'b0;
                        best_reg     <= '0;
                        status_reg   <= iptl_pkg::ST_OK;
                        if (s_tdata[1:0] == iptl_pkg::OP_LOOKUP) begin
                            found_reg <= root_mark_reg;
                            best_reg  <= root_mark_reg ? root_len_reg : '0;
                        end
                        if (s_tdata[1:0] == iptl_pkg::OP_LOOKUP
                            || s_tdata[1:0] == iptl_pkg::OP_INSERT
                            || s_tdata[1:0] == iptl_pkg::OP_DELETE) begin
                            state_reg <= S_WALK;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_WALK: begin
                    if (op_reg == iptl_pkg::OP_LOOKUP) begin
                        if (level_reg == ABITS || nx == '0) begin
                            state_reg <= S_FIN;
                        end else begin
                            cur_idx_reg <= nx;
                            state_reg   <= S_LOAD;
                        end
                    end else if (level_reg == len_reg) begin
                        state_reg <= S_FIN;
                    end else if (nx != '0) begin
                        par_idx_reg  <= cur_idx_reg;
                        par_zero_reg <= cur_zero_reg;
                        par_one_reg  <= cur_one_reg;
                        par_mark_reg <= cur_mark_reg;
                        par_len_reg  <= cur_len_reg;
                        lastbit_reg  <= bit_cur;
                        cur_idx_reg  <= nx;
                        state_reg    <= S_LOAD;
                    end else if (op_reg == iptl_pkg::OP_DELETE) begin
                        status_reg <= iptl_pkg::ST_NOT_FOUND;
                        state_reg  <= S_FIN;
                    end else if (rel_cnt_reg != '0) begin
                        state_reg <= S_POP;
                    end else if (fresh_reg < NODES) begin
                        new_idx_reg <= fresh_reg[IW-1:0];
                        fresh_reg   <= fresh_reg + CW'(1);
                        state_reg   <= S_LINK;
                    end else begin
                        status_reg <= iptl_pkg::ST_FULL;
                        state_reg  <= S_FIN;
                    end
                end
                S_LOAD: begin
                    cur_zero_reg <= rd_zero;
                    cur_one_reg  <= rd_one;
                    cur_mark_reg <= rd_mark;
                    cur_len_reg  <= rd_len;
                    addr_reg     <= addr_reg << 1;
                    level_reg    <= level_reg + PW'(1);
                    if (op_reg == iptl_pkg::OP_LOOKUP && rd_mark
                        && (!found_reg || rd_len > best_reg)) begin
                        found_reg <= 1'b1;
                        best_reg  <= rd_len;
                    end
                    state_reg <= S_WALK;
                end
                S_POP: begin
                    rel_cnt_reg <= rel_dec;
                    new_idx_reg <= stack_rdata;
                    state_reg   <= S_LINK;
                end
                S_LINK: begin
                    cur_idx_reg  <= new_idx_reg;
                    cur_zero_reg <= '0;
                    cur_one_reg  <= '0;
                    cur_mark_reg <= 1'b0;
                    cur_len_reg  <= '0;
                    addr_reg     <= addr_reg << 1;
                    level_reg    <= level_reg + PW'(1);
                    state_reg    <= S_CLEAR;
                end
                S_CLEAR: begin
                    state_reg <= S_WALK;
                end
                S_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_found_reg  <= found_reg;
                        m_len_reg    <= best_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_len_reg, m_found_reg, m_status_reg};

`include "ipv4_prefix_trie_lpm_macros.svh"

    `IPTL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted transaction did not make the block busy")
    `IPTL_ASSERT_SAME(a_fresh_bound, aclk, aresetn, 1'b1, fresh_reg <= NODES && rel_cnt_reg <= NODES, "node pool counters out of range")
    `IPTL_ASSERT_SAME(a_no_match_on_error, aclk, aresetn, m_tvalid && m_tdata[1:0] != iptl_pkg::ST_OK, m_tdata[8:2] == '0, "error result carries match fields")

endmodule
